// ----- hw/rtl/utf8s_pkg.sv -----
package utf8s_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned HOLD_DEPTH  = 3;
	localparam int unsigned BURST_DEPTH = 4;

	localparam logic [BYTE_W-1:0] REPL_RESET = 8'h3F;

	typedef logic [BYTE_W-1:0] byte_t;

	// group of up to four result bytes caused by one input item
	typedef struct packed {
		byte_t [BURST_DEPTH-1:0] bytes;
		logic  [BURST_DEPTH-1:0] repl;
		logic  [1:0]             last_idx;
		logic                    eob;
	} burst_t;

	// length of the form a lead byte opens, zero for no lead byte
	function automatic logic [2:0] lead_len(input byte_t b);
		logic [2:0] len;
		len = 3'd0;
		if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end
		return len;
	endfunction

endpackage

// ----- hw/rtl/utf8s_frame.sv -----
module utf8s_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  utf8s_pkg::byte_t data_s1,
	input  logic            eob_s1,
	input  utf8s_pkg::byte_t repl_byte,
	output logic            burst_valid,
	output utf8s_pkg::burst_t burst
);
	import utf8s_pkg::*;

	byte_t      held_q [HOLD_DEPTH];
	logic [1:0] held_cnt_q;
	logic [2:0] seq_len_q;

	logic       cont, ascii, in_form;
	logic       complete, overrun, extend, flush, fresh, fresh_hold;
	logic       prefix_en, final_en;
	logic [2:0] len;
	logic [1:0] plen;
	logic [2:0] count;
	byte_t      final_byte;
	logic       final_repl;

	always_comb begin
		cont     = (data_s1[7:6] == 2'b10);
		ascii    = !data_s1[7];
		len      = lead_len(data_s1);
		in_form  = (held_cnt_q != 2'd0);

		complete   = in_form && cont && (({1'b0, held_cnt_q} + 3'd1) == seq_len_q);
		overrun    = in_form && cont && !complete && (eob_s1 || held_cnt_q == 2'd3);
		extend     = in_form && cont && !complete && !overrun;
		flush      = in_form && !cont;
		fresh      = !in_form || !cont;
		fresh_hold = fresh && !ascii && (len != 3'd0) && !eob_s1;

		prefix_en = complete || overrun || flush;
		final_en  = complete || overrun || (fresh && !fresh_hold);
		plen      = prefix_en ? held_cnt_q : 2'd0;
		count     = {1'b0, plen} + {2'b00, final_en};

		if (complete || (fresh && ascii)) begin
			final_byte = data_s1;
			final_repl = 1'b0;
		end else begin
			final_byte = repl_byte;
			final_repl = 1'b1;
		end

		burst.bytes = '0;
		burst.repl  = '0;
		// held bytes first: passed as is on a complete form, replaced otherwise
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			if (2'(i) < plen) begin
				burst.bytes[i] = complete ? held_q[i] : repl_byte;
				burst.repl[i]  = !complete;
			end
		end
		burst.bytes[plen] = final_byte;
		burst.repl[plen]  = final_repl;
		burst.last_idx    = 2'(count - 3'd1);
		burst.eob         = eob_s1;
		burst_valid       = (count != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			seq_len_q  <= 3'd0;
		end else if (advance) begin
			if (eob_s1 || complete || overrun || (fresh && !fresh_hold)) begin
				held_cnt_q <= 2'd0;
				seq_len_q  <= 3'd0;
			end else if (extend) begin
				held_cnt_q <= held_cnt_q + 2'd1;
			end else if (fresh_hold) begin
				held_cnt_q <= 2'd1;
				seq_len_q  <= len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (fresh_hold) begin
				held_q[0] <= data_s1;
			end else if (extend) begin
				case (held_cnt_q)
					2'd1:    held_q[1] <= data_s1;
					2'd2:    held_q[2] <= data_s1;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- hw/rtl/utf8s_drain.sv -----
module utf8s_drain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  utf8s_pkg::burst_t burst,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output utf8s_pkg::byte_t  out_byte,
	output logic              was_replaced,
	output logic              run_last,
	output logic              stream_end
);
	import utf8s_pkg::*;

	logic       valid_s2_q;
	burst_t     burst_s2;
	logic [1:0] pos_q;
	logic       take, last;

	assign take = valid_s2_q && out_ready;
	assign last = (pos_q == burst_s2.last_idx);
	assign free = !valid_s2_q || (take && last);

	assign out_valid    = valid_s2_q;
	assign out_byte     = burst_s2.bytes[pos_q];
	assign was_replaced = burst_s2.repl[pos_q];
	assign run_last     = last;
	assign stream_end   = last && burst_s2.eob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
			pos_q      <= 2'd0;
		end else if (load) begin
			valid_s2_q <= 1'b1;
			pos_q      <= 2'd0;
		end else if (take) begin
			// advance through the group, drop it after its last byte
			if (last) begin
				valid_s2_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_s2 <= burst;
		end
	end

endmodule

// ----- hw/rtl/utf8_sanitizer.sv -----
// channel | signals                                       | direction
// input   | in_valid, in_ready, data_byte, end_of_buffer  | in
// output  | out_valid, out_ready, out_byte, was_replaced, | out
//         | run_last, stream_end                          |
// config  | cfg_wr_en, cfg_wr_data                        | in
//
// An item sits in the input register, is decoded there into a group
// of zero to four result bytes, and moves into the result register.
// The result register hands out one byte per cycle while out_ready is high and
// loads the next group as the last byte goes; ASCII items stream at one per cycle.
// Reset clears the held form and sets the replacement byte to '?'.
// A stalled output holds the result group, then the input register, then in_ready.
module utf8_sanitizer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  utf8s_pkg::byte_t data_byte,
	input  logic             end_of_buffer,
	output logic             out_valid,
	input  logic             out_ready,
	output utf8s_pkg::byte_t out_byte,
	output logic             was_replaced,
	output logic             run_last,
	output logic             stream_end,
	input  logic             cfg_wr_en,
	input  utf8s_pkg::byte_t cfg_wr_data
);
	import utf8s_pkg::*;

	byte_t  repl_q;
	logic   valid_s1_q;
	byte_t  data_s1;
	logic   eob_s1;
	logic   free, advance, burst_valid;
	burst_t burst;

	assign advance  = valid_s1_q && free;
	assign in_ready = !valid_s1_q || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_wr_en) begin
			repl_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	utf8s_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_s1     (data_s1),
		.eob_s1      (eob_s1),
		.repl_byte   (repl_q),
		.burst_valid (burst_valid),
		.burst       (burst)
	);

	utf8s_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && burst_valid),
		.burst        (burst),
		.free         (free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.was_replaced (was_replaced),
		.run_last     (run_last),
		.stream_end   (stream_end)
	);

endmodule

// ----- bench/utf8_sanitizer_test.sv -----
`timescale 1ns / 100ps

module utf8_sanitizer_test;
	import utf8s_pkg::*;

	typedef struct packed {
		byte_t value;
		logic  eob;
	} raw_item_t;

	typedef struct packed {
		byte_t value;
		logic  repl;
		logic  last;
		logic  send;
	} clean_item_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	byte_t data_byte = '0;
	logic  end_of_buffer = 1'b0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	byte_t out_byte;
	logic  was_replaced;
	logic  run_last;
	logic  stream_end;
	logic  cfg_wr_en = 1'b0;
	byte_t cfg_wr_data = '0;

	raw_item_t   byte_feed_q[$];
	clean_item_t clean_bytes_q[$];
	clean_item_t burst_q[$];
	raw_item_t   feed_item;
	clean_item_t want;

	// mirror of the sanitizer state
	byte_t       repl_mirror = REPL_RESET;
	byte_t       hold_buf[3];
	int unsigned hold_cnt = 0;
	int unsigned form_len = 0;

	int   errors = 0;
	int   feed_gap = 0;
	int   drain_gap = 0;
	logic idle_en = 1'b1;
	logic hold_req = 1'b0;
	logic rx_hold = 1'b0;

	utf8_sanitizer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.was_replaced  (was_replaced),
		.run_last      (run_last),
		.stream_end    (stream_end),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned form_length(input byte_t b);
		int unsigned len;
		casez (b)
			8'b110?_????: len = 2;
			8'b1110_????: len = 3;
			8'b1111_0???: len = 4;
			default:      len = 0;
		endcase
		return len;
	endfunction

	function automatic void emit(input byte_t b, input logic replaced);
		clean_item_t r;
		r.value = b;
		r.repl  = replaced;
		r.last  = 1'b0;
		r.send  = 1'b0;
		burst_q.push_back(r);
	endfunction

	function automatic void clear_hold();
		hold_buf[0] = '0;
		hold_buf[1] = '0;
		hold_buf[2] = '0;
		hold_cnt = 0;
		form_len = 0;
	endfunction

	function automatic void flush_held();
		for (int i = 0; i < hold_cnt; i++)
			emit(repl_mirror, 1'b1);
		clear_hold();
	endfunction

	function automatic void judge_new(input byte_t b, input logic eob);
		int unsigned len;
		len = form_length(b);
		if (!b[7]) begin
			emit(b, 1'b0);
		end else if (len == 0 || eob) begin
			emit(repl_mirror, 1'b1);
		end else begin
			hold_buf[0] = b;
			hold_cnt = 1;
			form_len = len;
		end
	endfunction

	// work out the cleaned bytes one accepted raw byte causes
	function automatic void sanitize_byte(input byte_t b, input logic eob);
		burst_q.delete();
		if (hold_cnt != 0) begin
			if (b[7:6] == 2'b10) begin
				if (hold_cnt + 1 == form_len) begin
					for (int i = 0; i < hold_cnt; i++)
						emit(hold_buf[i], 1'b0);
					emit(b, 1'b0);
					clear_hold();
				end else if (eob || hold_cnt >= 3) begin
					flush_held();
					emit(repl_mirror, 1'b1);
				end else begin
					hold_buf[hold_cnt] = b;
					hold_cnt++;
				end
			end else begin
				flush_held();
				judge_new(b, eob);
			end
		end else begin
			judge_new(b, eob);
		end
		if (burst_q.size() != 0) begin
			burst_q[burst_q.size()-1].last = 1'b1;
			burst_q[burst_q.size()-1].send = eob;
		end
		if (eob)
			clear_hold();
		foreach (burst_q[i])
			clean_bytes_q.push_back(burst_q[i]);
	endfunction

	function automatic void add_item(input byte_t b, input logic eob);
		raw_item_t it;
		it.value = b;
		it.eob   = eob;
		byte_feed_q.push_back(it);
	endfunction

	function automatic byte_t lead_of(input int unsigned len);
		byte_t b;
		case (len)
			1:       b = byte_t'($urandom_range(8'h00, 8'h7F));
			2:       b = byte_t'($urandom_range(8'hC0, 8'hDF));
			3:       b = byte_t'($urandom_range(8'hE0, 8'hEF));
			default: b = byte_t'($urandom_range(8'hF0, 8'hF7));
		endcase
		return b;
	endfunction

	// mostly well-formed forms with random content, some truncated, some noise
	function automatic int unsigned add_chunk();
		int unsigned kind;
		int unsigned len;
		int unsigned conts;
		logic        eob_here;
		byte_t       cont;
		kind = $urandom_range(0, 9);
		eob_here = ($urandom_range(0, 7) == 0);
		if (kind < 7) begin
			len = $urandom_range(1, 4);
			add_item(lead_of(len), eob_here && len == 1);
			for (int i = 1; i < len; i++) begin
				cont = byte_t'($urandom_range(8'h80, 8'hBF));
				add_item(cont, eob_here && i == len - 1);
			end
			return len;
		end else if (kind == 7) begin
			len = $urandom_range(2, 4);
			conts = $urandom_range(0, len - 2);
			eob_here = 1'($urandom_range(0, 1));
			add_item(lead_of(len), eob_here && conts == 0);
			for (int i = 1; i <= conts; i++) begin
				cont = byte_t'($urandom_range(8'h80, 8'hBF));
				add_item(cont, eob_here && i == conts);
			end
			return conts + 1;
		end else begin
			add_item(byte_t'($urandom_range(0, 255)), eob_here);
			return 1;
		end
	endfunction

	function automatic void add_random(input int unsigned count);
		int unsigned added;
		added = 0;
		while (added < count)
			added += add_chunk();
	endfunction

	task automatic report_mismatch(input string what, input byte_t got, input byte_t exp_val);
		$display("%0t: %s got %h expected %h", $realtime, what, got, exp_val);
		errors++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		#1;
		while (byte_feed_q.size() != 0 || in_valid || clean_bytes_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		// a held lead byte causes no result; let the pipeline settle
		repeat (8) @(posedge clk);
	endtask

	task automatic write_replacement(input byte_t v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		repl_mirror = v;
	endtask

	// driver: offer raw bytes, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			data_byte     <= '0;
			end_of_buffer <= 1'b0;
			feed_gap      <= 0;
		end else begin
			if (in_valid && in_ready)
				sanitize_byte(data_byte, end_of_buffer);
			if (!in_valid || in_ready) begin
				if (feed_gap != 0) begin
					feed_gap <= feed_gap - 1;
					in_valid <= 1'b0;
				end else if (idle_en && $urandom_range(0, 15) == 0) begin
					feed_gap <= int'($urandom_range(0, 17));
					in_valid <= 1'b0;
				end else if (byte_feed_q.size() != 0) begin
					feed_item = byte_feed_q.pop_front();
					in_valid      <= 1'b1;
					data_byte     <= feed_item.value;
					end_of_buffer <= feed_item.eob;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted item with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			drain_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (clean_bytes_q.size() == 0) begin
					report_mismatch("unexpected item, out_byte", out_byte, '0);
				end else begin
					want = clean_bytes_q.pop_front();
					if (out_byte !== want.value)
						report_mismatch("out_byte", out_byte, want.value);
					if (was_replaced !== want.repl)
						report_mismatch("was_replaced", byte_t'(was_replaced), byte_t'(want.repl));
					if (run_last !== want.last)
						report_mismatch("run_last", byte_t'(run_last), byte_t'(want.last));
					if (stream_end !== want.send)
						report_mismatch("stream_end", byte_t'(stream_end), byte_t'(want.send));
				end
			end
			if (drain_gap != 0) begin
				drain_gap <= drain_gap - 1;
				out_ready <= 1'b0;
			end else if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 11) == 0) begin
				drain_gap <= int'($urandom_range(0, 17));
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long receiver stall so the block fills and backs up its input
	initial begin
		wait (hold_req);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		clear_hold();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed bytes with the reset replacement
		add_item(8'h00, 1'b0);
		add_item(8'h7F, 1'b0);
		add_item(8'hC2, 1'b0);
		add_item(8'hA9, 1'b0);
		add_item(8'hE2, 1'b0);
		add_item(8'h82, 1'b0);
		add_item(8'hAC, 1'b0);
		add_item(8'hF0, 1'b0);
		add_item(8'h9F, 1'b0);
		add_item(8'h98, 1'b0);
		add_item(8'h80, 1'b0);
		add_item(8'h80, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(8'hF8, 1'b0);
		// lead byte at buffer end
		add_item(8'hC3, 1'b1);
		// incomplete form at buffer end
		add_item(8'hE2, 1'b0);
		add_item(8'h82, 1'b1);
		// form interrupted by ASCII: three replacements and the new byte
		add_item(8'hF0, 1'b0);
		add_item(8'h9F, 1'b0);
		add_item(8'h98, 1'b0);
		add_item(8'h41, 1'b0);
		// form interrupted by a new lead byte
		add_item(8'hE2, 1'b0);
		add_item(8'hC3, 1'b0);
		add_item(8'hA9, 1'b0);
		add_item(8'h41, 1'b1);
		wait_drained();

		write_replacement(8'h00);
		add_random(80);
		wait_drained();

		write_replacement(8'hFF);
		add_random(80);
		wait_drained();

		write_replacement(byte_t'($urandom_range(0, 255)));
		hold_req = 1'b1;
		add_random(80);
		wait_drained();

		// last stretch runs at full rate
		idle_en <= 1'b0;
		write_replacement(byte_t'($urandom_range(0, 255)));
		add_random(100);
		wait_drained();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
